// ----- rtl/core/wimds_pkg.sv -----
// Package for the wide integer multiply, divide and shift unit.
// Holds widths, operation codes and the cell payload struct; no dependencies.
package wimds_pkg;
  localparam int W = 128;
  localparam int DW = 8;
  localparam int NDC = W / DW;

  typedef enum logic [3:0] {
    OP_UMUL = 4'd0,
    OP_UDIV = 4'd1,
    OP_UREM = 4'd2,
    OP_SHR  = 4'd3,
    OP_SHL  = 4'd4,
    OP_SMUL = 4'd5,
    OP_SDIV = 4'd6,
    OP_SREM = 4'd7,
    OP_SRA  = 4'd8
  } op_t;

  typedef struct packed {
    logic         vld;
    logic [3:0]   kind;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] r;
    logic [W-1:0] q;
    logic         fix;
    logic         neg;
    logic [W-1:0] res;
  } cell_t;
endpackage

// ----- rtl/core/wimds_cell.sv -----
// One cell of the multiply/divide chain: one restoring-divide step or one
// 8-bit multiply digit. Depends on wimds_pkg.
module wimds_cell import wimds_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  is_mul,
  input  logic  [7:0] digit,
  input  cell_t din,
  output cell_t dout
);
  logic [W-1:0] rs;
  logic [W:0]   df;
  logic [W-1:0] pp;
  cell_t        nx;

  always_comb begin
    nx = din;
    rs = {din.r[W-2:0], din.a[W-1]};
    df = {1'b0, rs} - {1'b0, din.b};
    pp = '0;
    if (is_mul) begin
      pp = (din.b * din.a[DW*digit[3:0] +: DW]) << (DW * digit[3:0]);
      nx.r = din.r + pp;
    end else if (din.kind != OP_UMUL && din.kind != OP_SMUL) begin
      nx.a = {din.a[W-2:0], 1'b0};
      nx.r = df[W] ? rs : df[W-1:0];
      nx.q = {din.q[W-2:0], ~df[W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.kind <= din.kind; dout.a <= nx.a; dout.b <= din.b;
      dout.r <= nx.r; dout.q <= nx.q; dout.fix <= din.fix;
      dout.neg <= din.neg; dout.res <= din.res;
    end
  end
endmodule

// ----- rtl/core/wide_integer_mul_div_shift.sv -----
// Wide integer multiply/divide/shift unit: 128-bit operands, one result.
// Pipeline: 130 register stages (front stage, 128 cells, output).
// Throughput: one beat per cycle while not stalled; a beat advances one cell per cycle
// through the chain while the chain is not held.
// Stall: the whole chain holds while the output is full and not taken.
// Reset: synchronous, clears valid bits only.
module wide_integer_mul_div_shift import wimds_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [3:0]   s_tuser,  // kind
  input  logic [263:0] s_tdata,  // a_low, a_high, b_low, b_high, shift_amount
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata   // result_low, result_high
);
  cell_t ch [0:W];
  cell_t f;
  logic  en;
  logic [W-1:0] a, b, na, nb, sh;
  logic [7:0] amt;
  logic sgn, eqab, bmin;
  logic [W-1:0] fin;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign a = s_tdata[127:0];
  assign b = s_tdata[255:128];
  assign amt = s_tdata[263:256];
  assign na = -a;
  assign nb = -b;
  assign eqab = a == b;
  assign bmin = b == {1'b1, {(W-1){1'b0}}};

  always_comb begin
    f = '0;
    f.vld = s_tvalid;
    f.kind = s_tuser;
    f.a = a; f.b = b;
    sh = '0;
    unique case (s_tuser) inside
      OP_SHR: sh = amt[7] ? '0 : a >> amt[6:0];
      OP_SHL: sh = amt[7] ? '0 : a << amt[6:0];
      OP_SRA: begin
        if (amt[7]) sh = {W{a[W-1]}};
        else sh = $signed(a) >>> amt[6:0];
      end
      OP_SDIV, OP_SREM: begin
        f.a = a[W-1] ? na : a;
        f.b = b[W-1] ? nb : b;
        if (eqab) begin
          f.fix = 1'b1; f.res = (s_tuser == OP_SDIV) ? W'(1) : '0;
        end else if (bmin) begin
          f.fix = 1'b1; f.res = (s_tuser == OP_SDIV) ? '0 : a;
        end
        f.neg = (s_tuser == OP_SDIV) ? (a[W-1] ^ b[W-1]) : a[W-1];
      end
      default: sh = '0;
    endcase
    if (s_tuser == OP_SHR || s_tuser == OP_SHL || s_tuser == OP_SRA) begin
      f.fix = 1'b1; f.res = sh;
    end
    if (s_tuser > OP_SRA) f.fix = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) ch[0].vld <= 1'b0;
    else if (en) ch[0].vld <= f.vld;
    if (en) begin
      ch[0].kind <= f.kind; ch[0].a <= f.a; ch[0].b <= f.b; ch[0].r <= f.r;
      ch[0].q <= f.q; ch[0].fix <= f.fix; ch[0].neg <= f.neg; ch[0].res <= f.res;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    logic m;
    assign m = ch[i].kind == OP_UMUL || ch[i].kind == OP_SMUL;
    wimds_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .is_mul(m && (i < NDC)),
      .digit(8'(i)),
      .din(ch[i]), .dout(ch[i+1])
    );
  end

  always_comb begin
    sgn = 1'b0;
    fin = '0;
    case (ch[W].kind) inside
      OP_UMUL, OP_SMUL: fin = ch[W].r;
      OP_UDIV: fin = ch[W].q;
      OP_UREM: fin = ch[W].r;
      OP_SDIV: begin sgn = ch[W].neg; fin = sgn ? -ch[W].q : ch[W].q; end
      OP_SREM: begin sgn = ch[W].neg; fin = sgn ? -ch[W].r : ch[W].r; end
      default: fin = '0;
    endcase
    if (ch[W].fix) fin = ch[W].res;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= ch[W].vld;
    if (en) m_tdata <= fin;
  end
endmodule

// ----- rtl/core/wimds_checker.sv -----
// Port-level checker for the wide integer multiply/divide/shift unit.
// Depends on wide_integer_mul_div_shift; attached by bind.
module wimds_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
endmodule

bind wide_integer_mul_div_shift wimds_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- verif/testbench.sv -----
// Testbench for wide_integer_mul_div_shift: drives multiply, divide and shift beats
// through a random-gap stream driver and checks each result against a local predictor.
// Depends on wimds_pkg and the RTL top module.
`timescale 1ns / 1ps
module testbench;
  import wimds_pkg::*;

  typedef struct {
    logic [3:0]   kind;
    logic [127:0] a;
    logic [127:0] b;
    logic [7:0]   sh;
  } op_item_t;

  localparam logic [127:0] MIN_NEG = {1'b1, 127'd0};
  localparam logic [127:0] ALL_ONE = {128{1'b1}};
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [3:0] s_tuser = '0;
  logic [263:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;

  op_item_t pending_ops[$];
  logic [127:0] expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  int hold_off = 0;
  bit hold_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  bit drain_wait = 0;

  wide_integer_mul_div_shift DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [255:0] div_restore(logic [127:0] y, logic [127:0] d);
    logic [127:0] r;
    logic [127:0] q;
    r = '0;
    q = '0;
    for (int i = 0; i < 128; i++) begin
      r = {r[126:0], y[127]};
      y = y << 1;
      q = q << 1;
      if (r >= d) begin
        q[0] = 1'b1;
        r = r - d;
      end
    end
    return {r, q};
  endfunction

  function automatic logic [127:0] predict_result(op_item_t it);
    logic [255:0] qr;
    logic [127:0] ma;
    logic [127:0] mb;
    logic na;
    logic nb;
    na = it.a[127];
    nb = it.b[127];
    ma = na ? -it.a : it.a;
    mb = nb ? -it.b : it.b;
    case (it.kind) inside
      OP_UMUL, OP_SMUL: return it.a * it.b;
      OP_UDIV: begin qr = div_restore(it.a, it.b); return qr[127:0]; end
      OP_UREM: begin qr = div_restore(it.a, it.b); return qr[255:128]; end
      OP_SHR: return (it.sh >= 128) ? '0 : it.a >> it.sh;
      OP_SHL: return (it.sh >= 128) ? '0 : it.a << it.sh;
      OP_SDIV: begin
        if (it.a == it.b) return 128'd1;
        if (it.b == MIN_NEG) return '0;
        qr = div_restore(ma, mb);
        return (na != nb) ? -qr[127:0] : qr[127:0];
      end
      OP_SREM: begin
        if (it.a == it.b) return '0;
        if (it.b == MIN_NEG) return it.a;
        qr = div_restore(ma, mb);
        return na ? -qr[255:128] : qr[255:128];
      end
      OP_SRA: begin
        if (it.sh >= 128) return na ? ALL_ONE : '0;
        return $signed(it.a) >>> it.sh;
      end
      default: return '0;
    endcase
  endfunction

  function automatic logic [127:0] rand_wide();
    logic [127:0] v;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = ALL_ONE;
      2: v = MIN_NEG;
      3: v = v >> $urandom_range(0, 127);
      4: v = -(v >> $urandom_range(64, 127));
      5: v = 128'd1 << $urandom_range(0, 127);
      default: ;
    endcase
    return v;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 99) < 40) return 0;
    if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic push_op(logic [3:0] k, logic [127:0] a, logic [127:0] b, logic [7:0] s);
    op_item_t it;
    it.kind = k;
    it.a = a;
    it.b = b;
    it.sh = s;
    pending_ops.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    op_item_t it;
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_result(pending_ops.pop_front()));
        send_gap = rand_gap();
      end
      if (drain_wait && pending_ops.size() > 0 && pending_ops[0].kind == OP_SHL
          && pending_ops[0].sh == 8'd77 && expected_results.size() > 0) begin
        s_tvalid <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        it = pending_ops[0];
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {it.sh, it.b, it.a};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (results_seen >= 300 && !hold_done) begin
        hold_done <= 1'b1;
        hold_off <= 400;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [127:0] exp_res;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat %h", $time, m_tdata);
        end else begin
          exp_res = expected_results.pop_front();
          if (m_tdata[63:0] !== exp_res[63:0]) begin
            errors++;
            $display("%0t: result_low expected %h actual %h", $time, exp_res[63:0],
                     m_tdata[63:0]);
          end
          if (m_tdata[127:64] !== exp_res[127:64]) begin
            errors++;
            $display("%0t: result_high expected %h actual %h", $time, exp_res[127:64],
                     m_tdata[127:64]);
          end
        end
      end
      if (hold_off > 0) begin
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[wide_integer_mul_div_shift] ERROR");
      $finish;
    end
  end

  initial begin
    logic [3:0] k;
    logic [7:0] s;
    // directed: extremes and special cases
    push_op(OP_UMUL, ALL_ONE, ALL_ONE, 8'd0);
    push_op(OP_SMUL, MIN_NEG, ALL_ONE, 8'd0);
    push_op(OP_UDIV, 128'd12345, '0, 8'd0);
    push_op(OP_UREM, 128'd12345, '0, 8'd0);
    push_op(OP_UDIV, ALL_ONE, 128'd7, 8'd0);
    push_op(OP_SDIV, 128'd55, 128'd55, 8'd0);
    push_op(OP_SREM, '0, '0, 8'd0);
    push_op(OP_SDIV, 128'd99, MIN_NEG, 8'd0);
    push_op(OP_SREM, -128'd99, MIN_NEG, 8'd0);
    push_op(OP_SDIV, 128'd5, '0, 8'd0);
    push_op(OP_SDIV, -128'd5, '0, 8'd0);
    push_op(OP_SREM, -128'd5, '0, 8'd0);
    push_op(OP_SDIV, MIN_NEG, 128'd3, 8'd0);
    push_op(OP_SREM, MIN_NEG, -128'd3, 8'd0);
    push_op(OP_SHR, ALL_ONE, '0, 8'd128);
    push_op(OP_SHL, ALL_ONE, '0, 8'd255);
    push_op(OP_SRA, MIN_NEG, '0, 8'd200);
    push_op(OP_SRA, MIN_NEG, '0, 8'd64);
    push_op(OP_SHR, MIN_NEG, '0, 8'd127);
    push_op(OP_SHL, 128'd1, '0, 8'd64);
    push_op(OP_SRA, ALL_ONE >> 1, '0, 8'd0);
    push_op(4'd9, ALL_ONE, ALL_ONE, 8'd3);
    push_op(4'd15, ALL_ONE, ALL_ONE, 8'd255);
    // random part; the sender waits for a full drain at the marker beat
    for (int i = 0; i < 1650; i++) begin
      k = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      s = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 128));
      if (i == 800) begin
        k = OP_SHL;
        s = 8'd77;
      end else if (k == OP_SHL && s == 8'd77) begin
        s = 8'd76;
      end
      push_op(k, rand_wide(), rand_wide(), s);
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    drain_wait = 1;
    wait (pending_ops.size() == 0);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Ran %0d result beats over all nine kinds, unused kinds, divide and shift corners,",
             results_seen);
    $display("with random gaps, a long output stall and a full drain pause.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[wide_integer_mul_div_shift] OK");
    end else begin
      $display("[wide_integer_mul_div_shift] ERROR");
    end
    $finish;
  end
endmodule

// ----- wide_integer_mul_div_shift.f -----
rtl/core/wimds_pkg.sv
rtl/core/wimds_cell.sv
rtl/core/wide_integer_mul_div_shift.sv
rtl/core/wimds_checker.sv
verif/testbench.sv
